/* design/ffca_pkg.sv */
package ffca_pkg;

	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 17;
	localparam int ALIGN_W = 13;
	localparam int ADDR_W  = 16;
	localparam int STAT_W  = 3;

	localparam int MIN_ALIGN = 8;
	localparam int MAX_ALIGN = 4096;
	localparam int POOL_MIN  = 64;
	localparam int POOL_MAX  = 65536;

	// padding fits below 2*MAX_ALIGN, stored padding is padding minus header
	localparam int PAD_W  = 13;
	localparam int LPAD_W = 12;
	localparam int REQ_W  = SIZE_W + 1;

	// remainder unit: bits retired per cycle and steps per remainder
	localparam int REM_BITS  = 4;
	localparam int DIV_STEPS = ADDR_W / REM_BITS;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_POOL = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_RESET,
		CMD_UNDEF
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_NOFIT,
		ST_BAD,
		ST_UNKNOWN,
		ST_FULL
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_LOAD,
		OP_ST_BAD,
		OP_ST_NOFIT,
		OP_ST_FULL,
		OP_ST_UNKNOWN,
		OP_POOL_RESET,
		OP_IDX_CLR,
		OP_IDX_INC,
		OP_SLOT_CLR,
		OP_SLOT_INC,
		OP_FRD,
		OP_FCAP,
		OP_PAD,
		OP_REQ,
		OP_ALLOC,
		OP_RD_NEXT,
		OP_WR_DN,
		OP_FCNT_DEC,
		OP_LRD,
		OP_LCAP,
		OP_PREV,
		OP_MERGE_BOTH,
		OP_MERGE_PREV,
		OP_MERGE_NEXT,
		OP_INS_PREP,
		OP_RD_PREV,
		OP_WR_UP,
		OP_INSERT,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_A_RD,
		S_A_CAP,
		S_A_DIV,
		S_A_CMP,
		S_A_SLOT,
		S_R_RD,
		S_R_WR,
		S_F_LRD,
		S_F_LCHK,
		S_F_RD,
		S_F_CAP,
		S_F_DEC,
		S_I_RD,
		S_I_WR,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic cmd_alloc;
		logic cmd_reset;
		logic bad_req;
		logic idx_end;
		logic rem_done;
		logic fit;
		logic slot_end;
		logic slot_free;
		logic exact;
		logic rm_end;
		logic live_hit;
		logic past;
		logic m_next;
		logic m_prev;
		logic fcnt_full;
		logic ins_end;
		logic out_free;
	} dp_stat_t;

endpackage

/* design/ffca_if.sv */
interface ffca_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ffca_pkg::CMD_W-1:0]    cmd;
	logic [ffca_pkg::SIZE_W-1:0]   req_size;
	logic [ffca_pkg::ALIGN_W-1:0]  alignment;
	logic [ffca_pkg::ADDR_W-1:0]   address;

	modport source (output valid, cmd, req_size, alignment, address, input ready);
	modport sink (input valid, cmd, req_size, alignment, address, output ready);
endinterface

interface ffca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffca_pkg::STAT_W-1:0]   status;
	logic [ffca_pkg::ADDR_W-1:0]   data_offset;
	logic [ffca_pkg::SIZE_W-1:0]   used_bytes;

	modport source (output valid, status, data_offset, used_bytes, input ready);
	modport sink (input valid, status, data_offset, used_bytes, output ready);
endinterface

/* design/ffca_ram.sv */
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/ffca_rem.sv */
module ffca_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ffca_pkg::ADDR_W-1:0]  dividend,
	input  logic [ffca_pkg::ALIGN_W-1:0] divisor,
	output logic [ffca_pkg::ALIGN_W-1:0] rem,
	output logic                         done
);
	import ffca_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  num_q;
	logic [ALIGN_W-1:0] rem_q;
	logic [ADDR_W-1:0]  num_d;
	logic [ALIGN_W-1:0] rem_d;

	// retire REM_BITS dividend bits, restoring compare and subtract each
	always_comb begin
		logic [ALIGN_W:0] t;
		rem_d = rem_q;
		num_d = num_q;
		for (int b = 0; b < REM_BITS; b++) begin
			t = {rem_d, num_d[ADDR_W-1]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_d = t[ALIGN_W-1:0];
			num_d = {num_d[ADDR_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

/* design/ffca_dp.sv */
module ffca_dp #(
	parameter int FREE_SLOTS      = 64,
	parameter int LIVE_SLOTS      = 64,
	parameter int HEADER_BYTES    = 16,
	parameter int MIN_ALLOC_BYTES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffca_pkg::dp_op_t             op,
	output ffca_pkg::dp_stat_t           stat,
	input  logic [ffca_pkg::CMD_W-1:0]   in_cmd,
	input  logic [ffca_pkg::SIZE_W-1:0]  in_size,
	input  logic [ffca_pkg::ALIGN_W-1:0] in_align,
	input  logic [ffca_pkg::ADDR_W-1:0]  in_addr,
	input  logic [ffca_pkg::SIZE_W-1:0]  pool_size,
	input  logic                         rsp_ready,
	output logic                         rsp_valid,
	output logic [ffca_pkg::STAT_W-1:0]  rsp_status,
	output logic [ffca_pkg::ADDR_W-1:0]  rsp_data,
	output logic [ffca_pkg::SIZE_W-1:0]  rsp_used
);
	import ffca_pkg::*;

	localparam int FI_W  = $clog2(FREE_SLOTS + 1);
	localparam int FA_W  = $clog2(FREE_SLOTS);
	localparam int LI_W  = $clog2(LIVE_SLOTS + 1);
	localparam int LA_W  = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
	localparam int F_DW  = ADDR_W + SIZE_W;
	localparam int L_DW  = ADDR_W + SIZE_W + LPAD_W;
	localparam int NSTEP = (HEADER_BYTES + MIN_ALIGN - 1) / MIN_ALIGN;

	// command registers
	cmd_t               cmd_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ALIGN_W-1:0] al_q;
	logic [ADDR_W-1:0]  addr_q;

	// table state
	logic [FI_W-1:0]       fcnt_q;
	logic [SIZE_W-1:0]     used_q;
	logic [LIVE_SLOTS-1:0] vld_q;

	// walk registers
	logic [FI_W-1:0]    idx_q;
	logic [FI_W-1:0]    pos_q;
	logic [LI_W-1:0]    slot_q;
	logic [ADDR_W-1:0]  ent_base_q;
	logic [SIZE_W-1:0]  ent_len_q;
	logic [ADDR_W-1:0]  prev_base_q;
	logic [SIZE_W-1:0]  prev_len_q;
	logic [PAD_W-1:0]   pad_q;
	logic [REQ_W-1:0]   req_q;
	logic [ADDR_W-1:0]  start_q;
	logic [SIZE_W-1:0]  len_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  data_q;

	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ADDR_W-1:0]  out_data_q;
	logic [SIZE_W-1:0]  out_used_q;

	logic               f_we;
	logic [FA_W-1:0]    f_waddr;
	logic [FA_W-1:0]    f_raddr;
	logic [F_DW-1:0]    f_wdata;
	logic [F_DW-1:0]    f_rdata;
	logic [L_DW-1:0]    l_wdata;
	logic [L_DW-1:0]    l_rdata;
	logic [ADDR_W-1:0]  rd_base;
	logic [SIZE_W-1:0]  rd_len;
	logic [ADDR_W-1:0]  lr_addr;
	logic [SIZE_W-1:0]  lr_len;
	logic [LPAD_W-1:0]  lr_pad;
	logic [FI_W-1:0]    idx_p1;
	logic [FI_W-1:0]    idx_m1;
	logic [LA_W-1:0]    slot_a;
	logic [ALIGN_W-1:0] rem;
	logic               rem_done;
	logic [PAD_W-1:0]   pad_c;
	logic [REQ_W-1:0]   req_c;
	logic [ADDR_W-1:0]  data_c;
	logic               idx_end;
	logic               exact;

	assign rd_base = f_rdata[F_DW-1 -: ADDR_W];
	assign rd_len  = f_rdata[SIZE_W-1:0];
	assign lr_addr = l_rdata[L_DW-1 -: ADDR_W];
	assign lr_len  = l_rdata[LPAD_W +: SIZE_W];
	assign lr_pad  = l_rdata[LPAD_W-1:0];
	assign idx_p1  = idx_q + 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	assign slot_a  = slot_q[LA_W-1:0];
	assign data_c  = ent_base_q + ADDR_W'(pad_q);
	assign req_c   = REQ_W'(size_q) + REQ_W'(pad_q);
	assign idx_end = (idx_q == fcnt_q);
	assign exact   = ({1'b0, ent_len_q} == req_q);

	// padding: up to the next alignment multiple, then whole alignments until the header fits
	always_comb begin
		pad_c = PAD_W'(al_q) - PAD_W'(rem);
		for (int k = 0; k < NSTEP; k++) begin
			if (pad_c < PAD_W'(HEADER_BYTES)) begin
				pad_c = pad_c + PAD_W'(al_q);
			end
		end
	end

	ffca_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == OP_FCAP),
		.dividend (rd_base),
		.divisor  (al_q),
		.rem      (rem),
		.done     (rem_done)
	);

	ffca_ram #(.WIDTH(F_DW), .DEPTH(FREE_SLOTS)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	assign l_wdata = {data_c, SIZE_W'(req_q), LPAD_W'(pad_q - PAD_W'(HEADER_BYTES))};

	ffca_ram #(.WIDTH(L_DW), .DEPTH(LIVE_SLOTS)) u_live_ram (
		.clk   (clk),
		.we    (op == OP_ALLOC),
		.waddr (slot_a),
		.wdata (l_wdata),
		.raddr (slot_a),
		.rdata (l_rdata)
	);

	always_comb begin
		case (op)
			OP_RD_NEXT: f_raddr = idx_p1[FA_W-1:0];
			OP_RD_PREV: f_raddr = idx_m1[FA_W-1:0];
			default:    f_raddr = idx_q[FA_W-1:0];
		endcase
	end

	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q[FA_W-1:0];
		f_wdata = f_rdata;
		case (op)
			OP_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {ADDR_W'(0), SIZE_W'(POOL_MAX)};
			end
			OP_POOL_RESET: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {ADDR_W'(0), pool_size};
			end
			OP_ALLOC: begin
				f_we    = !exact;
				f_wdata = {ent_base_q + ADDR_W'(req_q), ent_len_q - SIZE_W'(req_q)};
			end
			OP_WR_DN, OP_WR_UP: begin
				f_we = 1'b1;
			end
			OP_MERGE_BOTH: begin
				f_we    = 1'b1;
				f_waddr = idx_m1[FA_W-1:0];
				f_wdata = {prev_base_q, prev_len_q + len_q + ent_len_q};
			end
			OP_MERGE_PREV: begin
				f_we    = 1'b1;
				f_waddr = idx_m1[FA_W-1:0];
				f_wdata = {prev_base_q, prev_len_q + len_q};
			end
			OP_MERGE_NEXT: begin
				f_we    = 1'b1;
				f_wdata = {start_q, ent_len_q + len_q};
			end
			OP_INSERT: begin
				f_we    = 1'b1;
				f_wdata = {start_q, len_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q      <= FI_W'(1);
			used_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				OP_POOL_RESET: begin
					fcnt_q <= FI_W'(1);
					used_q <= '0;
					vld_q  <= '0;
				end
				OP_ALLOC: begin
					vld_q[slot_a] <= 1'b1;
					used_q        <= used_q + SIZE_W'(req_q);
				end
				OP_FCNT_DEC: begin
					fcnt_q <= fcnt_q - 1'b1;
				end
				OP_MERGE_BOTH, OP_MERGE_PREV, OP_MERGE_NEXT: begin
					vld_q[slot_a] <= 1'b0;
					used_q        <= used_q - len_q;
				end
				OP_INSERT: begin
					vld_q[slot_a] <= 1'b0;
					used_q        <= used_q - len_q;
					fcnt_q        <= fcnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q    <= cmd_t'(in_cmd);
				size_q   <= in_size;
				al_q     <= in_align;
				addr_q   <= in_addr;
				status_q <= ST_OK;
				data_q   <= '0;
			end
			OP_ST_BAD:     status_q <= ST_BAD;
			OP_ST_NOFIT:   status_q <= ST_NOFIT;
			OP_ST_FULL:    status_q <= ST_FULL;
			OP_ST_UNKNOWN: status_q <= ST_UNKNOWN;
			OP_IDX_CLR:    idx_q <= '0;
			OP_IDX_INC:    idx_q <= idx_p1;
			OP_SLOT_CLR:   slot_q <= '0;
			OP_SLOT_INC:   slot_q <= slot_q + 1'b1;
			OP_FCAP: begin
				ent_base_q <= rd_base;
				ent_len_q  <= rd_len;
			end
			OP_PAD: pad_q <= pad_c;
			OP_REQ: begin
				req_q  <= req_c;
				slot_q <= '0;
			end
			OP_ALLOC: data_q <= data_c;
			OP_WR_DN: idx_q <= idx_p1;
			OP_WR_UP: idx_q <= idx_m1;
			OP_LCAP: begin
				start_q <= addr_q - ADDR_W'(HEADER_BYTES) - ADDR_W'(lr_pad);
				len_q   <= lr_len;
				idx_q   <= '0;
			end
			OP_PREV: begin
				prev_base_q <= rd_base;
				prev_len_q  <= rd_len;
				idx_q       <= idx_p1;
			end
			OP_INS_PREP: begin
				pos_q <= idx_q;
				idx_q <= fcnt_q;
			end
			OP_OUT: begin
				out_status_q <= status_q;
				out_data_q   <= data_q;
				out_used_q   <= used_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.cmd_alloc = (cmd_q == CMD_ALLOC);
		stat.cmd_reset = (cmd_q == CMD_RESET);
		stat.bad_req   = (cmd_q == CMD_UNDEF) ||
			((cmd_q == CMD_ALLOC) && ((size_q < SIZE_W'(MIN_ALLOC_BYTES)) ||
			(al_q < ALIGN_W'(MIN_ALIGN)) || (al_q > ALIGN_W'(MAX_ALIGN))));
		stat.idx_end   = idx_end;
		stat.rem_done  = rem_done;
		stat.fit       = ({1'b0, ent_len_q} >= req_c);
		stat.slot_end  = (slot_q == LI_W'(LIVE_SLOTS));
		stat.slot_free = !vld_q[slot_a];
		stat.exact     = exact;
		stat.rm_end    = (idx_p1 >= fcnt_q);
		stat.live_hit  = (lr_addr == addr_q);
		stat.past      = (rd_base > start_q);
		stat.m_next    = !idx_end &&
			(({2'b00, start_q} + {1'b0, len_q}) == {2'b00, ent_base_q});
		stat.m_prev    = (idx_q != '0) &&
			(({2'b00, prev_base_q} + {1'b0, prev_len_q}) == {2'b00, start_q});
		stat.fcnt_full = (fcnt_q >= FI_W'(FREE_SLOTS));
		stat.ins_end   = (idx_q == pos_q);
		stat.out_free  = !out_valid_q || rsp_ready;
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_data   = out_data_q;
	assign rsp_used   = out_used_q;

endmodule

/* design/ffca_ctrl.sv */
module ffca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ffca_pkg::dp_stat_t stat,
	output ffca_pkg::dp_op_t   op
);
	import ffca_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_INIT: begin
				op      = OP_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.bad_req) begin
					op      = OP_ST_BAD;
					state_d = S_DONE;
				end else if (stat.cmd_reset) begin
					op      = OP_POOL_RESET;
					state_d = S_DONE;
				end else if (stat.cmd_alloc) begin
					op      = OP_IDX_CLR;
					state_d = S_A_RD;
				end else begin
					op      = OP_SLOT_CLR;
					state_d = S_F_LRD;
				end
			end
			S_A_RD: begin
				if (stat.idx_end) begin
					op      = OP_ST_NOFIT;
					state_d = S_DONE;
				end else begin
					op      = OP_FRD;
					state_d = S_A_CAP;
				end
			end
			S_A_CAP: begin
				op      = OP_FCAP;
				state_d = S_A_DIV;
			end
			S_A_DIV: begin
				if (stat.rem_done) begin
					op      = OP_PAD;
					state_d = S_A_CMP;
				end
			end
			S_A_CMP: begin
				if (stat.fit) begin
					op      = OP_REQ;
					state_d = S_A_SLOT;
				end else begin
					op      = OP_IDX_INC;
					state_d = S_A_RD;
				end
			end
			S_A_SLOT: begin
				if (stat.slot_end) begin
					op      = OP_ST_FULL;
					state_d = S_DONE;
				end else if (stat.slot_free) begin
					op      = OP_ALLOC;
					state_d = stat.exact ? S_R_RD : S_DONE;
				end else begin
					op = OP_SLOT_INC;
				end
			end
			S_R_RD: begin
				if (stat.rm_end) begin
					op      = OP_FCNT_DEC;
					state_d = S_DONE;
				end else begin
					op      = OP_RD_NEXT;
					state_d = S_R_WR;
				end
			end
			S_R_WR: begin
				op      = OP_WR_DN;
				state_d = S_R_RD;
			end
			S_F_LRD: begin
				if (stat.slot_end) begin
					op      = OP_ST_UNKNOWN;
					state_d = S_DONE;
				end else if (!stat.slot_free) begin
					op      = OP_LRD;
					state_d = S_F_LCHK;
				end else begin
					op = OP_SLOT_INC;
				end
			end
			S_F_LCHK: begin
				if (stat.live_hit) begin
					op      = OP_LCAP;
					state_d = S_F_RD;
				end else begin
					op      = OP_SLOT_INC;
					state_d = S_F_LRD;
				end
			end
			S_F_RD: begin
				if (stat.idx_end) begin
					state_d = S_F_DEC;
				end else begin
					op      = OP_FRD;
					state_d = S_F_CAP;
				end
			end
			S_F_CAP: begin
				if (stat.past) begin
					op      = OP_FCAP;
					state_d = S_F_DEC;
				end else begin
					op      = OP_PREV;
					state_d = S_F_RD;
				end
			end
			S_F_DEC: begin
				if (!stat.m_next && !stat.m_prev && stat.fcnt_full) begin
					op      = OP_ST_FULL;
					state_d = S_DONE;
				end else if (stat.m_prev && stat.m_next) begin
					op      = OP_MERGE_BOTH;
					state_d = S_R_RD;
				end else if (stat.m_prev) begin
					op      = OP_MERGE_PREV;
					state_d = S_DONE;
				end else if (stat.m_next) begin
					op      = OP_MERGE_NEXT;
					state_d = S_DONE;
				end else begin
					op      = OP_INS_PREP;
					state_d = S_I_RD;
				end
			end
			S_I_RD: begin
				if (stat.ins_end) begin
					op      = OP_INSERT;
					state_d = S_DONE;
				end else begin
					op      = OP_RD_PREV;
					state_d = S_I_WR;
				end
			end
			S_I_WR: begin
				op      = OP_WR_UP;
				state_d = S_I_RD;
			end
			S_DONE: begin
				if (stat.out_free) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/first_fit_coalescing_allocator.sv */
// Work: allocate tries free segments in order, passes occupied live slots, and moves
//   segments when a segment is used up; free searches live slots, passes segments and
//   moves segments; pool reset or bad request goes straight to the result.
// Throughput: one item at a time, set by the free table walk, which reads one entry
//   at a time, and the remainder unit (4 bits per cycle) used for each segment tried.
// Reset: arst_n clears all control state; the first state after reset writes the single free segment.
module first_fit_coalescing_allocator #(
	parameter int FREE_SLOTS      = 64,
	parameter int LIVE_SLOTS      = 64,
	parameter int HEADER_BYTES    = 16,
	parameter int MIN_ALLOC_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ffca_cmd_if.sink                      cmd_ch,
	ffca_rsp_if.source                    rsp_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffca_pkg::PADDR_W-1:0]  paddr,
	input  logic [ffca_pkg::PDATA_W-1:0]  pwdata,
	output logic [ffca_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ffca_pkg::*;

	logic [SIZE_W-1:0] pool_q;
	logic [SIZE_W-1:0] wr_val;
	logic              cfg_wr;
	dp_op_t            op;
	dp_stat_t          stat;

	// Configuration: one register, the pool size used by the next pool reset.
	// Clamp the written value into the legal pool range before storing it.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL);

	always_comb begin
		wr_val = pwdata[SIZE_W-1:0];
		if (wr_val < SIZE_W'(POOL_MIN)) begin
			wr_val = SIZE_W'(POOL_MIN);
		end else if (wr_val > SIZE_W'(POOL_MAX)) begin
			wr_val = SIZE_W'(POOL_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= SIZE_W'(POOL_MAX);
		end else if (cfg_wr) begin
			pool_q <= wr_val;
		end
	end

	assign prdata = (paddr[2] == REG_POOL) ? PDATA_W'(pool_q) : '0;

	// Sequencer: walks the free and live tables one entry at a time and issues one
	// datapath operation per cycle unless it stalls. It takes a new item only when idle.
	ffca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (cmd_ch.ready),
		.stat     (stat),
		.op       (op)
	);

	// Datapath: free segment table and live table in RAM, live valid bits in
	// flops, remainder unit for the alignment padding, and the result register
	// that holds a finished item until the consumer takes it.
	ffca_dp #(
		.FREE_SLOTS      (FREE_SLOTS),
		.LIVE_SLOTS      (LIVE_SLOTS),
		.HEADER_BYTES    (HEADER_BYTES),
		.MIN_ALLOC_BYTES (MIN_ALLOC_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.stat       (stat),
		.in_cmd     (cmd_ch.cmd),
		.in_size    (cmd_ch.req_size),
		.in_align   (cmd_ch.alignment),
		.in_addr    (cmd_ch.address),
		.pool_size  (pool_q),
		.rsp_ready  (rsp_ch.ready),
		.rsp_valid  (rsp_ch.valid),
		.rsp_status (rsp_ch.status),
		.rsp_data   (rsp_ch.data_offset),
		.rsp_used   (rsp_ch.used_bytes)
	);

	// An accepted item is decoded next; the block never takes two in a row.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && cmd_ch.ready) |=> !cmd_ch.ready)
		else $error("item accepted while another is in work");

	// Only a successful allocate carries a data offset.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ch.valid && (rsp_ch.status != ST_OK)) |-> (rsp_ch.data_offset == '0))
		else $error("data offset on a failed item");

	// A new free segment goes in only while the free table has room.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_INSERT) |-> !stat.fcnt_full)
		else $error("insert into a full free table");

	// A result is loaded only when the output register is free.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT) |-> (!rsp_ch.valid || rsp_ch.ready))
		else $error("result overwritten before it was taken");

endmodule
